// File: src/tsv_cell_offset_scanner_defines.svh
// Assertion macros shared by the checker of the tab-separated cell scanner.
`ifndef TSV_CELL_OFFSET_SCANNER_DEFINES_SVH
`define TSV_CELL_OFFSET_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk and muted while rst_n is low.
`define TCOS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcos check failed");

// Next-cycle implication, sampled on clk and muted while rst_n is low.
`define TCOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcos check failed");

`endif

// File: src/tcos_pkg.sv
// Constants and types of the tab-separated cell scanner.
package tcos_pkg;

    localparam int unsigned MAX_BYTES   = 1048576;
    localparam int unsigned MAX_COLUMNS = 256;
    localparam int unsigned MAX_ROWS    = 65536;

    localparam int unsigned POS_W     = 21;
    localparam int unsigned OFF_W     = 20;
    localparam int unsigned ROW_W     = 17;
    localparam int unsigned COL_W     = 8;
    localparam int unsigned WIDTH_W   = 9;
    localparam int unsigned OUT_ROW_W = 16;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;

    typedef struct packed {
        logic                 cell_valid;
        logic [OUT_ROW_W-1:0] cell_row;
        logic [COL_W-1:0]     cell_column;
        logic [OFF_W-1:0]     cell_offset;
        logic [OFF_W-1:0]     cell_length;
        logic                 done_res;
        logic [WIDTH_W-1:0]   table_width;
        logic [ROW_W-1:0]     table_height;
        logic                 overflow;
    } cell_res_t;

endpackage

// File: src/tcos_scan_core.sv
// Scanner state and the per-byte cell splitting logic.
module tcos_scan_core
    import tcos_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       end_of_data,
    output logic       push,
    output cell_res_t  res
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [OFF_W-1:0]   start_reg, start_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic               known_reg, known_next;
    logic               cr_reg, cr_next;
    logic               skip_reg, skip_next;
    logic               ovf_reg, ovf_next;

    logic               is_tab;
    logic               is_nl;
    logic               row_room;
    logic [WIDTH_W-1:0] col_inc;
    logic [WIDTH_W-1:0] col_limit;
    logic               hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            start_reg <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            width_reg <= WIDTH_W'(1);
            known_reg <= 1'b0;
            cr_reg    <= 1'b0;
            skip_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            width_reg <= width_next;
            known_reg <= known_next;
            cr_reg    <= cr_next;
            skip_reg  <= skip_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign is_tab    = (data_byte == CH_TAB);
    assign is_nl     = (data_byte == CH_CR) || (data_byte == CH_LF);
    assign row_room  = (row_reg < ROW_W'(MAX_ROWS));
    assign col_inc   = {1'b0, col_reg} + WIDTH_W'(1);
    assign col_limit = known_reg ? width_reg : WIDTH_W'(MAX_COLUMNS);

    always_comb
    begin
        pos_next   = pos_reg;
        start_next = start_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        width_next = width_reg;
        known_next = known_reg;
        cr_next    = cr_reg;
        skip_next  = skip_reg;
        ovf_next   = ovf_reg;
        hit        = 1'b0;
        res        = '0;

        if (pos_reg >= POS_W'(MAX_BYTES))
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            if (cr_reg && (data_byte == CH_LF))
            begin
                // The LF of a CR LF pair only moves the next cell start.
                cr_next    = 1'b0;
                start_next = pos_reg[OFF_W-1:0] + OFF_W'(1);
            end
            else
            begin
                cr_next = (data_byte == CH_CR);
                if (is_tab || is_nl)
                begin
                    if (!skip_reg && row_room)
                    begin
                        hit             = 1'b1;
                        res.cell_row    = row_reg[OUT_ROW_W-1:0];
                        res.cell_column = col_reg;
                        res.cell_offset = start_reg;
                        res.cell_length = pos_reg[OFF_W-1:0] - start_reg;
                    end
                    if (is_tab)
                    begin
                        if (!skip_reg)
                        begin
                            if (col_inc >= col_limit)
                            begin
                                skip_next = 1'b1;
                                if (!known_reg)
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_inc[COL_W-1:0];
                                if (!known_reg)
                                begin
                                    width_next = col_inc + WIDTH_W'(1);
                                end
                            end
                        end
                    end
                    else
                    begin
                        known_next = 1'b1;
                        if (row_room)
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        col_next  = '0;
                        skip_next = 1'b0;
                    end
                    start_next = pos_reg[OFF_W-1:0] + OFF_W'(1);
                end
            end
            pos_next = pos_reg + POS_W'(1);
        end

        res.cell_valid   = hit;
        res.done_res     = end_of_data;
        res.table_width  = width_next;
        res.table_height = row_next;
        res.overflow     = ovf_next;
        push             = accept && (hit || end_of_data);

        // The final byte starts a fresh buffer; only the overflow flag survives.
        if (end_of_data)
        begin
            pos_next   = '0;
            start_next = '0;
            row_next   = '0;
            col_next   = '0;
            width_next = WIDTH_W'(1);
            known_next = 1'b0;
            cr_next    = 1'b0;
            skip_next  = 1'b0;
        end
    end

endmodule

// File: src/tcos_res_queue.sv
// Two-entry result queue that decouples the scanner from the output stall.
module tcos_res_queue
    import tcos_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cell_res_t push_data,
    input  logic      pop,
    output logic      full,
    output logic      not_empty,
    output cell_res_t head
);

    logic [1:0] count_reg, count_next;
    cell_res_t  slot0_reg;
    cell_res_t  slot1_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot0_reg;

    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && push)
        begin
            slot0_reg <= push_data;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= push_data;
            end
            else
            begin
                slot1_reg <= push_data;
            end
        end
    end

endmodule

// File: src/tsv_cell_offset_scanner.sv
// Top level of the tab-separated cell scanner.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------------
//   input   | in_valid / in_stall   | data_byte, end_of_data
//   output  | out_valid / out_stall | cell_valid .. overflow (one result or none)
//
// One byte is taken every cycle unless in_stall is high; the scanner state
// updates in the transaction's cycle; its result is registered in the queue.
// A two-entry result queue absorbs output stalls; in_stall rises only when
// both entries hold results that have not been taken.
// Reset clears the scanner state, the overflow flag and the queue at once.
module tsv_cell_offset_scanner
    import tcos_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 cell_valid,
    output logic [OUT_ROW_W-1:0] cell_row,
    output logic [COL_W-1:0]     cell_column,
    output logic [OFF_W-1:0]     cell_offset,
    output logic [OFF_W-1:0]     cell_length,
    output logic                 done_res,
    output logic [WIDTH_W-1:0]   table_width,
    output logic [ROW_W-1:0]     table_height,
    output logic                 overflow
);

    logic      accept;
    logic      push;
    logic      pop;
    logic      full;
    cell_res_t res;
    cell_res_t head;

    assign accept   = in_valid && !full;
    assign in_stall = full;
    assign pop      = out_valid && !out_stall;

    tcos_scan_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .push        (push),
        .res         (res)
    );

    tcos_res_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .pop       (pop),
        .full      (full),
        .not_empty (out_valid),
        .head      (head)
    );

    assign cell_valid   = head.cell_valid;
    assign cell_row     = head.cell_row;
    assign cell_column  = head.cell_column;
    assign cell_offset  = head.cell_offset;
    assign cell_length  = head.cell_length;
    assign done_res     = head.done_res;
    assign table_width  = head.table_width;
    assign table_height = head.table_height;
    assign overflow     = head.overflow;

endmodule

// File: src/tcos_checker.sv
// Port-level checker of the tab-separated cell scanner and its bind.
`include "tsv_cell_offset_scanner_defines.svh"

module tcos_checker
    import tcos_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 cell_valid,
    input logic [OUT_ROW_W-1:0] cell_row,
    input logic [COL_W-1:0]     cell_column,
    input logic [OFF_W-1:0]     cell_offset,
    input logic [OFF_W-1:0]     cell_length,
    input logic                 done_res,
    input logic [WIDTH_W-1:0]   table_width,
    input logic [ROW_W-1:0]     table_height,
    input logic                 overflow
);

    // A stalled result keeps every field.
    `TCOS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cell_valid) && $stable(cell_row) && $stable(cell_column) && $stable(cell_offset) && $stable(cell_length) && $stable(done_res) && $stable(table_width) && $stable(table_height) && $stable(overflow))

    // The input side is held back only while results wait.
    `TCOS_ASSERT_SAME(a_stall_has_results, in_stall, out_valid)

    // A reported cell lies inside the table width.
    `TCOS_ASSERT_SAME(a_col_in_width, out_valid && cell_valid, {1'b0, cell_column} < table_width)

    // A reported cell never lies below the current height.
    `TCOS_ASSERT_SAME(a_row_in_height, out_valid && cell_valid, {1'b0, cell_row} <= table_height)

    // Once shown, overflow stays set on every later transaction.
    `TCOS_ASSERT_NEXT(a_overflow_sticky, out_valid && !out_stall && overflow, !out_valid || overflow)

endmodule

bind tsv_cell_offset_scanner tcos_checker u_checker (.*);
